>>> rtl/csvtok_pkg.sv
// Package for the CSV byte tokenizer: result and state records, result kinds
// and the character codes the tokenizer reacts to. No dependencies.

package csvtok_pkg;

    localparam logic [1:0] KIND_BYTE     = 2'd0;
    localparam logic [1:0] KIND_CELL_END = 2'd1;
    localparam logic [1:0] KIND_ROW_END  = 2'd2;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  out_byte;
        logic [15:0] row_index;
        logic [7:0]  column_index;
        logic [8:0]  max_columns;
        logic        last;
    } result_t;

    typedef struct packed {
        logic        in_quote;
        logic        skip_lf;
        logic [15:0] row_counter;
        logic [7:0]  column_counter;
        logic [8:0]  widest_row;
    } tok_state_t;

endpackage

>>> rtl/csvtok_step.sv
// Tokenizer step logic: from the current state and one input byte, forms up
// to two results and the next state. Depends on csvtok_pkg.

module csvtok_step #(
    parameter int ROW_LIMIT = 65535,
    parameter int COL_LIMIT = 255
) (
    input  csvtok_pkg::tok_state_t cur,
    input  logic [7:0]             in_byte,
    input  logic                   end_of_data,
    output csvtok_pkg::tok_state_t nxt,
    output csvtok_pkg::result_t    res0,
    output logic                   res0_valid,
    output csvtok_pkg::result_t    res1,
    output logic                   res1_valid
);
    import csvtok_pkg::*;

    localparam logic [15:0] ROW_MAX = ROW_LIMIT[15:0];
    localparam logic [7:0]  COL_MAX = COL_LIMIT[7:0];

    tok_state_t mid;
    logic [8:0] cells0;
    logic [8:0] cells1;
    logic [8:0] widest1;

    assign cells0 = {1'b0, cur.column_counter} + 9'd1;

    always_comb begin
        mid            = cur;
        mid.skip_lf    = 1'b0;
        res0_valid     = 1'b0;
        res0.kind         = KIND_BYTE;
        res0.out_byte     = in_byte;
        res0.row_index    = cur.row_counter;
        res0.column_index = cur.column_counter;
        res0.max_columns  = cur.widest_row;
        res0.last         = 1'b0;
        if (cur.skip_lf && in_byte == CH_LF) begin
            res0_valid = 1'b0;
        end else if (cur.in_quote) begin
            if (in_byte == CH_QUOTE) begin
                mid.in_quote = 1'b0;
            end else if (in_byte == CH_CR) begin
                res0_valid    = 1'b1;
                res0.out_byte = CH_LF;
                mid.skip_lf   = 1'b1;
            end else begin
                res0_valid = 1'b1;
            end
        end else begin
            if (in_byte == CH_QUOTE) begin
                mid.in_quote = 1'b1;
            end else if (in_byte == CH_COMMA) begin
                res0_valid    = 1'b1;
                res0.kind     = KIND_CELL_END;
                res0.out_byte = 8'd0;
                if (cur.column_counter < COL_MAX) begin
                    mid.column_counter = cur.column_counter + 8'd1;
                end
            end else if (in_byte == CH_CR || in_byte == CH_LF) begin
                res0_valid    = 1'b1;
                res0.kind     = KIND_ROW_END;
                res0.out_byte = 8'd0;
                if (cells0 > cur.widest_row) begin
                    mid.widest_row = cells0;
                end
                res0.max_columns = mid.widest_row;
                if (cur.row_counter < ROW_MAX) begin
                    mid.row_counter = cur.row_counter + 16'd1;
                end
                mid.column_counter = 8'd0;
                mid.skip_lf        = (in_byte == CH_CR);
            end else begin
                res0_valid = 1'b1;
            end
        end
    end

    assign cells1  = {1'b0, mid.column_counter} + 9'd1;
    assign widest1 = (cells1 > mid.widest_row) ? cells1 : mid.widest_row;

    always_comb begin
        res1_valid        = end_of_data;
        res1.kind         = KIND_ROW_END;
        res1.out_byte     = 8'd0;
        res1.row_index    = mid.row_counter;
        res1.column_index = mid.column_counter;
        res1.max_columns  = widest1;
        res1.last         = 1'b1;
        if (end_of_data) begin
            nxt = '0;
        end else begin
            nxt = mid;
        end
    end

endmodule

>>> rtl/csv_byte_tokenizer.sv
// Top level of the CSV byte tokenizer: stream ports, tokenizer state and a
// three-entry result queue. Depends on csvtok_pkg and csvtok_step.

// One CSV byte is taken per transfer and tokenized in the same cycle; its
// results enter a three-entry result queue and appear on the master side
// in the next cycle at the earliest. A byte gives zero, one or two results
// (two only for the byte that carries end of data), and the master side
// sends one result per cycle, so with m_tready held high the block takes one
// byte every cycle and pauses after an end-of-data byte that produced two
// results. s_tready is high while the queue holds at most one result.

module csv_byte_tokenizer #(
    parameter int MAX_ROWS = 65536,
    parameter int MAX_COLS = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic        s_tlast,   // end_of_data
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [7:0] out_byte, [23:8] row_index,
                                   // [31:24] column_index, [40:32] max_columns
    output logic [1:0]  m_tuser,   // [1:0] kind
    output logic        m_tlast    // last
);
    import csvtok_pkg::*;

    localparam int ROW_LIM = (MAX_ROWS - 1 > 65535) ? 65535 : MAX_ROWS - 1;
    localparam int COL_LIM = (MAX_COLS - 1 > 255) ? 255 : MAX_COLS - 1;

    tok_state_t state_reg;
    tok_state_t state_next;
    result_t    res0;
    result_t    res1;
    logic       res0_valid;
    logic       res1_valid;

    result_t    queue_reg [3];
    logic [1:0] wr_ptr_reg;
    logic [1:0] rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] wr_ptr_inc;
    logic [1:0] wr_ptr_inc2;
    logic [1:0] rd_ptr_inc;
    logic       in_xfer;
    logic       out_xfer;
    logic       push0;
    logic       push1;
    logic [1:0] push_count;
    result_t    head;

    csvtok_step #(
        .ROW_LIMIT(ROW_LIM),
        .COL_LIMIT(COL_LIM)
    ) u_step (
        .cur        (state_reg),
        .in_byte    (s_tdata),
        .end_of_data(s_tlast),
        .nxt        (state_next),
        .res0       (res0),
        .res0_valid (res0_valid),
        .res1       (res1),
        .res1_valid (res1_valid)
    );

    assign s_tready = (count_reg <= 2'd1);
    assign in_xfer  = s_tvalid && s_tready;
    assign m_tvalid = (count_reg != 2'd0);
    assign out_xfer = m_tvalid && m_tready;

    assign push0      = in_xfer && res0_valid;
    assign push1      = in_xfer && res1_valid;
    assign push_count = {1'b0, push0} + {1'b0, push1};

    assign wr_ptr_inc  = (wr_ptr_reg == 2'd2) ? 2'd0 : wr_ptr_reg + 2'd1;
    assign wr_ptr_inc2 = (wr_ptr_inc == 2'd2) ? 2'd0 : wr_ptr_inc + 2'd1;
    assign rd_ptr_inc  = (rd_ptr_reg == 2'd2) ? 2'd0 : rd_ptr_reg + 2'd1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= '0;
            wr_ptr_reg <= 2'd0;
            rd_ptr_reg <= 2'd0;
            count_reg  <= 2'd0;
        end else begin
            if (in_xfer) begin
                state_reg <= state_next;
            end
            if (push0 && push1) begin
                wr_ptr_reg <= wr_ptr_inc2;
            end else if (push0 || push1) begin
                wr_ptr_reg <= wr_ptr_inc;
            end
            if (out_xfer) begin
                rd_ptr_reg <= rd_ptr_inc;
            end
            count_reg <= count_reg + push_count - {1'b0, out_xfer};
        end
    end

    // payload: first result at the write pointer, second right after it
    always_ff @(posedge aclk) begin
        if (push0) begin
            queue_reg[wr_ptr_reg] <= res0;
            if (push1) begin
                queue_reg[wr_ptr_inc] <= res1;
            end
        end else if (push1) begin
            queue_reg[wr_ptr_reg] <= res1;
        end
    end

    assign head    = queue_reg[rd_ptr_reg];
    assign m_tdata = {7'd0, head.max_columns, head.column_index, head.row_index,
                      head.out_byte};
    assign m_tuser = head.kind;
    assign m_tlast = head.last;

endmodule
